[rtl/crfs_pkg.sv]
// ----------------------------------------------------------------------------
// crfs_pkg
// Shared types and constants of the circle raster frame store: command codes,
// field widths and the command and status bundles between control and datapath.
// ----------------------------------------------------------------------------
package crfs_pkg;

    localparam int unsigned COLOR_W  = 24;
    localparam int unsigned COORD_W  = 13;
    localparam int unsigned RADIUS_W = 12;
    localparam int unsigned PT_W     = 14;
    localparam int unsigned DEC_W    = 16;
    localparam int unsigned IDX_W    = 3;

    localparam int unsigned DEF_FRAME_WIDTH  = 128;
    localparam int unsigned DEF_FRAME_HEIGHT = 128;

    localparam logic [COLOR_W-1:0] WHITE = 24'hFFFFFF;

    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_SET    = 2'd1,
        CMD_FILL   = 2'd2,
        CMD_CIRCLE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        PK_SINGLE = 2'd0,
        PK_AXIAL  = 2'd1,
        PK_OCT    = 2'd2
    } t_pt_kind;

    typedef struct packed {
        logic             load;
        logic             pt_issue;
        t_pt_kind         pt_kind;
        logic [IDX_W-1:0] pt_idx;
        logic             circ_step;
        logic             sweep_start;
        logic             res_load;
    } t_dp_cmd;

    typedef struct packed {
        logic sweep_busy;
        logic pipe_busy;
        logic circ_more;
    } t_dp_status;

endpackage

[rtl/circle_raster_frame_store.sv]
// ----------------------------------------------------------------------------
// circle_raster_frame_store
// Frame store of 24-bit pixels with read, set, fill and midpoint circle commands.
// ----------------------------------------------------------------------------
// After reset the block clears the frame to white, one pixel per cycle, and
// takes no command until that pass ends. Every command returns one result
// beat, which carries the pixel color for a read of a point inside the frame
// and zero otherwise. A read or set goes through the point pipeline in front
// of the single memory write port and posts its result once that pipeline
// has drained. A fill posts its result once the sweep has written the whole
// frame, one store write per cycle. A circle issues four axial writes and then,
// for each of N midpoint steps (N is near 0.71*radius) that the loop test
// admits, one update and eight mirrored writes; it posts its result after the
// pipeline drain. The input is ready again in the cycle after a result is
// posted. Points outside the frame are dropped. A new command is accepted while
// the previous result still waits to be taken; its own result is then posted
// only once that earlier result is taken.
module circle_raster_frame_store
    import crfs_pkg::*;
#(
    parameter int unsigned FRAME_WIDTH  = DEF_FRAME_WIDTH,
    parameter int unsigned FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic        [1:0]          i_cmd,
    input  logic signed [COORD_W-1:0]  i_x_pos,
    input  logic signed [COORD_W-1:0]  i_y_pos,
    input  logic        [RADIUS_W-1:0] i_radius,
    input  logic        [COLOR_W-1:0]  i_color,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic        [COLOR_W-1:0]  o_pixel_color
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    t_cmd       in_cmd;

    assign in_cmd = t_cmd'(i_cmd);

    crfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (in_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_dp_cmd    (dp_cmd),
        .i_dp_status (dp_status)
    );

    crfs_datapath #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dp_cmd      (dp_cmd),
        .o_dp_status   (dp_status),
        .i_cmd         (in_cmd),
        .i_x_pos       (i_x_pos),
        .i_y_pos       (i_y_pos),
        .i_radius      (i_radius),
        .i_color       (i_color),
        .o_pixel_color (o_pixel_color)
    );

`ifndef SYNTHESIS
    a_no_accept_during_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> !dp_status.sweep_busy)
        else $error("command accepted while the frame sweep is running");

    a_one_command_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input still ready right after a command was accepted");

    a_result_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.res_load |-> (!dp_status.pipe_busy && !dp_status.sweep_busy))
        else $error("result posted before all pixel writes completed");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.res_load |-> (!o_out_valid || i_out_ready))
        else $error("pending result overwritten");
`endif

endmodule

[rtl/crfs_ctrl.sv]
// ----------------------------------------------------------------------------
// crfs_ctrl
// Command sequencer: accepts a command, steps the datapath through its pixel
// operations or frame sweep, waits for the pipeline to drain and posts a result.
// ----------------------------------------------------------------------------
module crfs_ctrl
    import crfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_cmd       i_cmd,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_dp_cmd    o_dp_cmd,
    input  t_dp_status i_dp_status
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SINGLE,
        S_FILL,
        S_AXIAL,
        S_CHECK,
        S_STEP,
        S_OCT,
        S_DRAIN
    } t_state;

    localparam logic [IDX_W-1:0] AXIAL_LAST = IDX_W'(3);
    localparam logic [IDX_W-1:0] OCT_LAST   = IDX_W'(7);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic             r_out_vld, n_out_vld;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_out_vld = r_out_vld & ~i_out_ready;
        o_dp_cmd  = '0;
        o_dp_cmd.pt_kind = PK_SINGLE;
        case (r_state)
            S_INIT: begin
                if (!i_dp_status.sweep_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_dp_cmd.load = 1'b1;
                    n_cnt         = '0;
                    case (i_cmd)
                        CMD_READ, CMD_SET: n_state = S_SINGLE;
                        CMD_FILL:          n_state = S_FILL;
                        default:           n_state = S_AXIAL;
                    endcase
                end
            end
            S_SINGLE: begin
                o_dp_cmd.pt_issue = 1'b1;
                o_dp_cmd.pt_kind  = PK_SINGLE;
                n_state           = S_DRAIN;
            end
            S_FILL: begin
                o_dp_cmd.sweep_start = 1'b1;
                n_state              = S_DRAIN;
            end
            S_AXIAL: begin
                o_dp_cmd.pt_issue = 1'b1;
                o_dp_cmd.pt_kind  = PK_AXIAL;
                o_dp_cmd.pt_idx   = r_cnt;
                n_cnt             = r_cnt + 1'b1;
                if (r_cnt == AXIAL_LAST) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_dp_status.circ_more ? S_STEP : S_DRAIN;
            end
            S_STEP: begin
                o_dp_cmd.circ_step = 1'b1;
                n_cnt              = '0;
                n_state            = S_OCT;
            end
            S_OCT: begin
                o_dp_cmd.pt_issue = 1'b1;
                o_dp_cmd.pt_kind  = PK_OCT;
                o_dp_cmd.pt_idx   = r_cnt;
                n_cnt             = r_cnt + 1'b1;
                if (r_cnt == OCT_LAST) begin
                    n_state = S_CHECK;
                end
            end
            S_DRAIN: begin
                if (!i_dp_status.pipe_busy && !i_dp_status.sweep_busy &&
                    (!r_out_vld || i_out_ready)) begin
                    o_dp_cmd.res_load = 1'b1;
                    n_out_vld         = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

[rtl/crfs_datapath.sv]
// ----------------------------------------------------------------------------
// crfs_datapath
// Circle decision registers, point generator, clip and address pipeline,
// frame store memory with its sweep writer, and the result register.
// ----------------------------------------------------------------------------
module crfs_datapath
    import crfs_pkg::*;
#(
    parameter int unsigned FRAME_WIDTH  = DEF_FRAME_WIDTH,
    parameter int unsigned FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_dp_cmd,
    output t_dp_status                 o_dp_status,
    input  t_cmd                       i_cmd,
    input  logic signed [COORD_W-1:0]  i_x_pos,
    input  logic signed [COORD_W-1:0]  i_y_pos,
    input  logic        [RADIUS_W-1:0] i_radius,
    input  logic        [COLOR_W-1:0]  i_color,
    output logic        [COLOR_W-1:0]  o_pixel_color
);

    localparam int unsigned DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic signed [PT_W-1:0] W_LIM = PT_W'(FRAME_WIDTH);
    localparam logic signed [PT_W-1:0] H_LIM = PT_W'(FRAME_HEIGHT);

    // Latched command fields.
    t_cmd                      r_cmd;
    logic signed [PT_W-1:0]    r_cx, r_cy;
    logic        [RADIUS_W-1:0] r_rad;
    logic        [COLOR_W-1:0] r_color;

    // Midpoint circle state.
    logic signed [DEC_W-1:0]   r_dec, r_incx, r_incy;
    logic        [RADIUS_W-1:0] r_px, r_py;
    logic signed [DEC_W-1:0]   n_dec, n_incx, n_incy;
    logic        [RADIUS_W-1:0] n_px, n_py;

    // Point pipeline.
    logic                      r_a_vld, r_a_rd;
    logic signed [PT_W-1:0]    r_a_x, r_a_y;
    logic                      r_b_vld, r_b_rd;
    logic        [AW-1:0]      r_b_addr;
    logic        [COLOR_W-1:0] r_b_color;
    logic signed [PT_W-1:0]    n_x, n_y;
    logic signed [PT_W-1:0]    s_rad, s_px, s_py, s_a, s_b;
    logic                      s_in_frame;
    logic        [AW-1:0]      s_addr;

    // Frame store and sweep writer.
    logic        [COLOR_W-1:0] r_mem [DEPTH];
    logic        [COLOR_W-1:0] r_mem_q;
    logic                      r_sweep_act;
    logic        [AW-1:0]      r_sweep_cnt;
    logic        [COLOR_W-1:0] r_sweep_color;
    logic                      s_we;
    logic        [AW-1:0]      s_waddr;
    logic        [COLOR_W-1:0] s_wdata;

    logic                      r_rd_hit;
    logic        [COLOR_W-1:0] r_pixel_color;

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_cmd   <= i_cmd;
            r_cx    <= PT_W'(i_x_pos);
            r_cy    <= PT_W'(i_y_pos);
            r_rad   <= i_radius;
            r_color <= i_color;
        end
    end

    always_comb begin
        n_incy = r_incy;
        n_py   = r_py;
        n_dec  = r_dec;
        if (!r_dec[DEC_W-1]) begin
            n_incy = r_incy + DEC_W'(2);
            n_py   = r_py - 1'b1;
            n_dec  = r_dec + n_incy;
        end
        n_px   = r_px + 1'b1;
        n_incx = r_incx + DEC_W'(2);
        n_dec  = n_dec + n_incx;
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_dec  <= DEC_W'(1) - DEC_W'(i_radius);
            r_incx <= DEC_W'(1);
            r_incy <= '0 - DEC_W'({i_radius, 1'b0});
            r_px   <= '0;
            r_py   <= i_radius;
        end else if (i_dp_cmd.circ_step) begin
            r_dec  <= n_dec;
            r_incx <= n_incx;
            r_incy <= n_incy;
            r_px   <= n_px;
            r_py   <= n_py;
        end
    end

    // Point generator: the index picks the axial point or the mirror image.
    always_comb begin
        s_rad = PT_W'(r_rad);
        s_px  = PT_W'(r_px);
        s_py  = PT_W'(r_py);
        s_a   = i_dp_cmd.pt_idx[2] ? s_py : s_px;
        s_b   = i_dp_cmd.pt_idx[2] ? s_px : s_py;
        n_x   = r_cx;
        n_y   = r_cy;
        case (i_dp_cmd.pt_kind)
            PK_AXIAL: begin
                case (i_dp_cmd.pt_idx[1:0])
                    2'd0:    n_y = r_cy + s_rad;
                    2'd1:    n_y = r_cy - s_rad;
                    2'd2:    n_x = r_cx + s_rad;
                    default: n_x = r_cx - s_rad;
                endcase
            end
            PK_OCT: begin
                n_x = i_dp_cmd.pt_idx[0] ? (r_cx - s_a) : (r_cx + s_a);
                n_y = i_dp_cmd.pt_idx[1] ? (r_cy - s_b) : (r_cy + s_b);
            end
            default: begin
                n_x = r_cx;
                n_y = r_cy;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.pt_issue) begin
            r_a_x  <= n_x;
            r_a_y  <= n_y;
            r_a_rd <= (i_dp_cmd.pt_kind == PK_SINGLE) && (r_cmd == CMD_READ);
        end
    end

    assign s_in_frame = !r_a_x[PT_W-1] && (r_a_x < W_LIM) &&
                        !r_a_y[PT_W-1] && (r_a_y < H_LIM);
    assign s_addr     = AW'(AW'(r_a_y[PT_W-2:0]) * AW'(FRAME_WIDTH)) +
                        AW'(r_a_x[PT_W-2:0]);

    always_ff @(posedge i_clk) begin
        r_b_addr  <= s_addr;
        r_b_rd    <= r_a_rd;
        r_b_color <= r_color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= i_dp_cmd.pt_issue;
            r_b_vld <= r_a_vld && s_in_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_act   <= 1'b1;
            r_sweep_cnt   <= '0;
            r_sweep_color <= WHITE;
        end else if (i_dp_cmd.sweep_start) begin
            r_sweep_act   <= 1'b1;
            r_sweep_cnt   <= '0;
            r_sweep_color <= r_color;
        end else if (r_sweep_act) begin
            r_sweep_cnt <= r_sweep_cnt + 1'b1;
            if (r_sweep_cnt == LAST_ADDR) begin
                r_sweep_act <= 1'b0;
            end
        end
    end

    assign s_we    = r_sweep_act || (r_b_vld && !r_b_rd);
    assign s_waddr = r_sweep_act ? r_sweep_cnt : r_b_addr;
    assign s_wdata = r_sweep_act ? r_sweep_color : r_b_color;

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_mem[s_waddr] <= s_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_vld && r_b_rd) begin
            r_mem_q <= r_mem[r_b_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_hit <= 1'b0;
        end else if (i_dp_cmd.load) begin
            r_rd_hit <= 1'b0;
        end else if (r_b_vld && r_b_rd) begin
            r_rd_hit <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.res_load) begin
            r_pixel_color <= r_rd_hit ? r_mem_q : '0;
        end
    end

    assign o_pixel_color          = r_pixel_color;
    assign o_dp_status.sweep_busy = r_sweep_act;
    assign o_dp_status.pipe_busy  = r_a_vld || r_b_vld;
    assign o_dp_status.circ_more  = (r_px < r_py);

endmodule
